// ----- src/anvig_pkg.sv -----
// Shared constants, register codes, types and shift tables for the alphanumeric cipher.
package anvig_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int SHIFT_W     = 5;
  localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH   = 2'd2;

  localparam int ALPHA_MOD = 26;
  localparam int DIGIT_MOD = 10;

  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE    = 8'h39;

  typedef logic [255:0][SHIFT_W-1:0] shift_tbl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic [LEN_W-1:0]  eff_len;
  } key_info_t;

  function automatic shift_tbl_t shift_tbl_f(int base, bit is_digit);
    shift_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      if (is_digit) begin
        tbl[i] = SHIFT_W'((i + 256 * DIGIT_MOD - base) % DIGIT_MOD);
      end else begin
        tbl[i] = SHIFT_W'((i + 256 * ALPHA_MOD - base) % ALPHA_MOD);
      end
    end
    return tbl;
  endfunction

  localparam shift_tbl_t UPPER_SHIFT = shift_tbl_f(int'(ASCII_UPPER_A), 1'b0);
  localparam shift_tbl_t LOWER_SHIFT = shift_tbl_f(int'(ASCII_LOWER_A), 1'b0);
  localparam shift_tbl_t DIGIT_SHIFT = shift_tbl_f(int'(ASCII_ZERO), 1'b1);

endpackage

// ----- src/anvig_key_store.sv -----
// Key length and key byte registers with key byte lookup by position.
module anvig_key_store #(
  parameter int KEY_MAX = anvig_pkg::KEY_MAX_DEF,
  parameter int POS_W   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [anvig_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [anvig_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [POS_W-1:0]                  pos_i,
  output anvig_pkg::key_info_t              info_o
);

  logic [anvig_pkg::LEN_W-1:0]                 key_len_q;
  logic [KEY_MAX-1:0][anvig_pkg::BYTE_W-1:0]   key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= anvig_pkg::LEN_W'(1);
    end else if (cfg_we_i && cfg_addr_i == anvig_pkg::CFG_KEY_LENGTH) begin
      key_len_q <= cfg_wdata_i[anvig_pkg::LEN_W-1:0];
    end
  end

  for (genvar b = 0; b < KEY_MAX; b++) begin : g_key_byte
    localparam logic [anvig_pkg::CFG_ADDR_W-1:0] WORD =
      (b < anvig_pkg::BYTES_PER_WORD) ? anvig_pkg::CFG_KEY_LOW : anvig_pkg::CFG_KEY_HIGH;
    localparam int LSB = (b % anvig_pkg::BYTES_PER_WORD) * anvig_pkg::BYTE_W;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q[b] <= '0;
      end else if (cfg_we_i && cfg_addr_i == WORD) begin
        key_q[b] <= cfg_wdata_i[LSB +: anvig_pkg::BYTE_W];
      end
    end
  end

  always_comb begin
    info_o.key_byte = key_q[pos_i];
    if (key_len_q == '0) begin
      info_o.eff_len = anvig_pkg::LEN_W'(1);
    end else if (key_len_q > anvig_pkg::LEN_W'(KEY_MAX)) begin
      info_o.eff_len = anvig_pkg::LEN_W'(KEY_MAX);
    end else begin
      info_o.eff_len = key_len_q;
    end
  end

endmodule

// ----- src/anvig_rotate.sv -----
// Character classifier and modular shift of letters and digits by a key byte.
module anvig_rotate (
  input  logic [anvig_pkg::BYTE_W-1:0] char_i,
  input  logic                         decrypt_i,
  input  logic [anvig_pkg::BYTE_W-1:0] key_byte_i,
  output logic [anvig_pkg::BYTE_W-1:0] char_o,
  output logic                         alnum_o
);

  logic                            is_upper;
  logic                            is_lower;
  logic                            is_digit;
  logic [anvig_pkg::BYTE_W-1:0]    base;
  logic [anvig_pkg::SHIFT_W-1:0]   modulus;
  logic [anvig_pkg::SHIFT_W-1:0]   shift;
  logic [anvig_pkg::SHIFT_W-1:0]   offset;
  logic [anvig_pkg::SHIFT_W:0]     sum;
  logic [anvig_pkg::SHIFT_W:0]     wrapped;

  assign is_upper = (char_i >= anvig_pkg::ASCII_UPPER_A) && (char_i <= anvig_pkg::ASCII_UPPER_Z);
  assign is_lower = (char_i >= anvig_pkg::ASCII_LOWER_A) && (char_i <= anvig_pkg::ASCII_LOWER_Z);
  assign is_digit = (char_i >= anvig_pkg::ASCII_ZERO) && (char_i <= anvig_pkg::ASCII_NINE);
  assign alnum_o  = is_upper || is_lower || is_digit;

  always_comb begin
    if (is_upper) begin
      base    = anvig_pkg::ASCII_UPPER_A;
      modulus = anvig_pkg::SHIFT_W'(anvig_pkg::ALPHA_MOD);
      shift   = anvig_pkg::UPPER_SHIFT[key_byte_i];
    end else if (is_lower) begin
      base    = anvig_pkg::ASCII_LOWER_A;
      modulus = anvig_pkg::SHIFT_W'(anvig_pkg::ALPHA_MOD);
      shift   = anvig_pkg::LOWER_SHIFT[key_byte_i];
    end else begin
      base    = anvig_pkg::ASCII_ZERO;
      modulus = anvig_pkg::SHIFT_W'(anvig_pkg::DIGIT_MOD);
      shift   = anvig_pkg::DIGIT_SHIFT[key_byte_i];
    end

    offset = anvig_pkg::SHIFT_W'(char_i - base);
    if (decrypt_i) begin
      sum = {1'b0, offset} + {1'b0, modulus} - {1'b0, shift};
    end else begin
      sum = {1'b0, offset} + {1'b0, shift};
    end
    wrapped = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;

    if (alnum_o) begin
      char_o = base + anvig_pkg::BYTE_W'(wrapped);
    end else begin
      char_o = char_i;
    end
  end

endmodule

// ----- src/alnum_vigenere_stream_cipher_unit.sv -----
// Top level of the alphanumeric Vigenere stream cipher: input stage, cipher and result register.
//
//   channel   handshake                   payload
//   input     in_valid_i / in_ready_o     char_in_i, decrypt_mode_i, message_start_i
//   output    out_valid_o / out_ready_i   char_out_o
//   config    cfg_we_i                    cfg_addr_i, cfg_wdata_i
//
// One byte per cycle unless the output stalls.
// The key position update and the shift table lookup sit between the input stage and
// the result register, so one byte can follow the next in every cycle the output does not stall.
// Reset clears the key position, key length (to one), key bytes and both valid flags.
// A stalled result holds the result register; the input stage still takes a byte while
// it is empty.
module alnum_vigenere_stream_cipher_unit #(
  parameter int KEY_MAX = anvig_pkg::KEY_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [anvig_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [anvig_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [anvig_pkg::BYTE_W-1:0]      char_in_i,
  input  logic                              decrypt_mode_i,
  input  logic                              message_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [anvig_pkg::BYTE_W-1:0]      char_out_o
);

  localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic                            in_vld_q;
  logic [anvig_pkg::BYTE_W-1:0]    in_char_q;
  logic                            in_dec_q;
  logic                            in_start_q;
  logic                            out_vld_q;
  logic [anvig_pkg::BYTE_W-1:0]    out_char_q;
  logic [anvig_pkg::BYTE_W-1:0]    out_char_d;
  logic [POS_W-1:0]                pos_q;
  logic [POS_W-1:0]                pos_d;
  logic [POS_W-1:0]                pos_cur;
  logic [POS_W:0]                  pos_next;
  logic                            alnum;
  logic                            out_adv;
  anvig_pkg::key_info_t            key_info;

  assign out_adv    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_adv;

  anvig_key_store #(
    .KEY_MAX (KEY_MAX),
    .POS_W   (POS_W)
  ) u_key_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_i       (pos_cur),
    .info_o      (key_info)
  );

  anvig_rotate u_rotate (
    .char_i     (in_char_q),
    .decrypt_i  (in_dec_q),
    .key_byte_i (key_info.key_byte),
    .char_o     (out_char_d),
    .alnum_o    (alnum)
  );

  always_comb begin
    pos_cur  = in_start_q ? '0 : pos_q;
    pos_next = {1'b0, pos_cur} + (POS_W + 1)'(1);
    if (!alnum) begin
      pos_d = pos_cur;
    end else if (anvig_pkg::LEN_W'(pos_next) >= key_info.eff_len) begin
      pos_d = '0;
    end else begin
      pos_d = pos_next[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          pos_q <= pos_d;
        end
      end
    end
  end

  // hold the input stage until its byte moves on
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_char_q  <= char_in_i;
      in_dec_q   <= decrypt_mode_i;
      in_start_q <= message_start_i;
    end
    if (out_adv && in_vld_q) begin
      out_char_q <= out_char_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign char_out_o  = out_char_q;

endmodule
